// ----- hw/rtl/midi_track_event_parser_unit_defines.svh -----
// ----------------------------------------------------------------------------
// MIDI track event parser - assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MTEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtep port check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MTEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtep port check failed");

`endif

// ----- hw/rtl/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser - package
// Phase codes, record and error codes, parser state and result types.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned VLQ_MAX_BYTES = 4;
  localparam int unsigned VAL_W         = 28;
  localparam int unsigned CNT_W         = 3;

  localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
  localparam logic [7:0] SYSEX_END         = 8'hF7;
  localparam logic [7:0] STATUS_META       = 8'hFF;
  localparam logic [7:0] STATUS_CHAN_FIRST = 8'h80;
  localparam logic [7:0] STATUS_CHAN_LAST  = 8'hEF;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
  localparam logic [3:0] KIND_PROGRAM      = 4'hC;
  localparam logic [3:0] KIND_PRESSURE     = 4'hD;

  typedef enum logic [9:0] {
    PH_DELTA   = 10'b00_0000_0001,
    PH_STATUS  = 10'b00_0000_0010,
    PH_SYSEX   = 10'b00_0000_0100,
    PH_MTYPE   = 10'b00_0000_1000,
    PH_MLEN    = 10'b00_0001_0000,
    PH_PAYLOAD = 10'b00_0010_0000,
    PH_DATA1   = 10'b00_0100_0000,
    PH_DATA2   = 10'b00_1000_0000,
    PH_ENDED   = 10'b01_0000_0000,
    PH_HALT    = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    REC_CHANNEL   = 2'd0,
    REC_META_HDR  = 2'd1,
    REC_META_DATA = 2'd2,
    REC_ERROR     = 2'd3
  } record_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_VLQ_LONG  = 2'd1,
    ERR_STATUS    = 2'd2,
    ERR_TRUNCATED = 2'd3
  } error_e;

  typedef struct packed {
    phase_e           phase;
    logic [VAL_W-1:0] vlq_acc;
    logic [CNT_W-1:0] vlq_cnt;
    logic [VAL_W-1:0] delta;
    logic [7:0]       status;
    logic [7:0]       meta_type;
    logic [VAL_W-1:0] remaining;
    logic [7:0]       first_data;
  } parse_state_t;

  typedef struct packed {
    record_kind_e     record_kind;
    logic [VAL_W-1:0] delta_time;
    logic [3:0]       channel;
    logic [3:0]       event_kind;
    logic [7:0]       meta_type;
    logic [VAL_W-1:0] meta_length;
    logic [7:0]       first_data;
    logic [7:0]       second_data;
    logic             last_of_event;
    logic             track_ended;
    error_e           error_code;
  } result_t;

  localparam parse_state_t ST_RESET = '{
    phase:      PH_DELTA,
    vlq_acc:    '0,
    vlq_cnt:    '0,
    delta:      '0,
    status:     '0,
    meta_type:  '0,
    remaining:  '0,
    first_data: '0
  };

  function automatic result_t make_error(error_e code);
    result_t r;
    r               = '0;
    r.record_kind   = REC_ERROR;
    r.last_of_event = 1'b1;
    r.error_code    = code;
    return r;
  endfunction

endpackage

// ----- hw/rtl/midi_track_event_parser_unit.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes track chunk bytes into channel, meta header, meta payload and error
// records.
// ----------------------------------------------------------------------------
// channel  dir  handshake             word
// in       in   in_valid_i/in_stall_o  data_byte, start_of_track, end_of_data
// out      out  out_valid_o/out_stall_i record_kind .. error_code
//
// One byte per cycle sustained while the result is not stalled.
// Path: input register, step logic, result register.
// Reset clears parser state and both valid flags.
// A stalled result holds; the input register still takes a word if it is empty.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit import mtep_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_track_i,
  input  logic             end_of_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       record_kind_o,
  output logic [VAL_W-1:0] delta_time_o,
  output logic [3:0]       channel_o,
  output logic [3:0]       event_kind_o,
  output logic [7:0]       meta_type_o,
  output logic [VAL_W-1:0] meta_length_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic             last_of_event_o,
  output logic             track_ended_o,
  output logic [1:0]       error_code_o
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   byte_q;
  logic         sot_q;
  logic         eod_q;
  parse_state_t st_q, st_d;
  logic         out_valid_q, out_valid_d;
  result_t      res_q;
  result_t      res_d;
  logic         res_v;
  logic         out_free;
  logic         advance;
  logic         in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  mtep_step u_step (
    .st_i             (st_q),
    .data_byte_i      (byte_q),
    .start_of_track_i (sot_q),
    .end_of_data_i    (eod_q),
    .st_o             (st_d),
    .res_o            (res_d),
    .res_valid_o      (res_v)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_v;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= ST_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      sot_q  <= start_of_track_i;
      eod_q  <= end_of_data_i;
    end
    if (advance && res_v) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = res_q.record_kind;
  assign delta_time_o    = res_q.delta_time;
  assign channel_o       = res_q.channel;
  assign event_kind_o    = res_q.event_kind;
  assign meta_type_o     = res_q.meta_type;
  assign meta_length_o   = res_q.meta_length;
  assign first_data_o    = res_q.first_data;
  assign second_data_o   = res_q.second_data;
  assign last_of_event_o = res_q.last_of_event;
  assign track_ended_o   = res_q.track_ended;
  assign error_code_o    = res_q.error_code;

endmodule

// ----- hw/rtl/mtep_step.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser - step logic
// Next parser state and optional result for one track byte.
// ----------------------------------------------------------------------------
module mtep_step import mtep_pkg::*; (
  input  parse_state_t st_i,
  input  logic [7:0]   data_byte_i,
  input  logic         start_of_track_i,
  input  logic         end_of_data_i,
  output parse_state_t st_o,
  output result_t      res_o,
  output logic         res_valid_o
);

  always_comb begin
    parse_state_t     cur;
    parse_state_t     nxt;
    result_t          res;
    logic             res_v;
    logic             err;
    logic             ended;
    logic             clean;
    logic [VAL_W-1:0] vlq_val;
    logic [CNT_W:0]   vlq_inc;
    logic             vlq_long;
    logic [VAL_W-1:0] rem_dec;
    logic [3:0]       kind;

    cur      = start_of_track_i ? ST_RESET : st_i;
    nxt      = cur;
    res      = '0;
    res_v    = 1'b0;
    err      = 1'b0;
    ended    = (cur.meta_type == META_END_OF_TRACK);
    vlq_val  = {cur.vlq_acc[VAL_W-8:0], data_byte_i[6:0]};
    vlq_inc  = {1'b0, cur.vlq_cnt} + {{CNT_W{1'b0}}, 1'b1};
    vlq_long = data_byte_i[7] && (vlq_inc >= (CNT_W+1)'(VLQ_MAX_BYTES));
    rem_dec  = cur.remaining - {{(VAL_W-1){1'b0}}, 1'b1};
    kind     = cur.status[7:4];

    unique case (cur.phase)
      PH_DELTA: begin
        nxt.vlq_acc = vlq_val;
        if (vlq_long) begin
          err = 1'b1;
          res = make_error(ERR_VLQ_LONG);
        end else if (!data_byte_i[7]) begin
          nxt.delta   = vlq_val;
          nxt.vlq_acc = '0;
          nxt.vlq_cnt = '0;
          nxt.phase   = PH_STATUS;
        end else begin
          nxt.vlq_cnt = vlq_inc[CNT_W-1:0];
        end
      end
      PH_STATUS: begin
        nxt.status = data_byte_i;
        if (data_byte_i == STATUS_SYSEX) begin
          nxt.phase = PH_SYSEX;
        end else if (data_byte_i == STATUS_META) begin
          nxt.phase = PH_MTYPE;
        end else if (data_byte_i < STATUS_CHAN_FIRST || data_byte_i > STATUS_CHAN_LAST) begin
          err = 1'b1;
          res = make_error(ERR_STATUS);
        end else begin
          nxt.phase = PH_DATA1;
        end
      end
      PH_SYSEX: begin
        if (data_byte_i == SYSEX_END) begin
          nxt.vlq_acc = '0;
          nxt.vlq_cnt = '0;
          nxt.phase   = PH_DELTA;
        end
      end
      PH_MTYPE: begin
        nxt.meta_type = data_byte_i;
        nxt.vlq_acc   = '0;
        nxt.vlq_cnt   = '0;
        nxt.phase     = PH_MLEN;
      end
      PH_MLEN: begin
        nxt.vlq_acc = vlq_val;
        if (vlq_long) begin
          err = 1'b1;
          res = make_error(ERR_VLQ_LONG);
        end else if (!data_byte_i[7]) begin
          nxt.vlq_cnt     = '0;
          nxt.remaining   = vlq_val;
          res.record_kind = REC_META_HDR;
          res.delta_time  = cur.delta;
          res.meta_type   = cur.meta_type;
          res.meta_length = vlq_val;
          res_v           = 1'b1;
          if (vlq_val == '0) begin
            res.last_of_event = 1'b1;
            res.track_ended   = ended;
            nxt.vlq_acc       = '0;
            nxt.phase         = ended ? PH_ENDED : PH_DELTA;
          end else begin
            nxt.phase = PH_PAYLOAD;
          end
        end else begin
          nxt.vlq_cnt = vlq_inc[CNT_W-1:0];
        end
      end
      PH_PAYLOAD: begin
        res.record_kind = REC_META_DATA;
        res.delta_time  = cur.delta;
        res.meta_type   = cur.meta_type;
        res.meta_length = cur.vlq_acc;
        res.first_data  = data_byte_i;
        res_v           = 1'b1;
        nxt.remaining   = rem_dec;
        if (rem_dec == '0) begin
          res.last_of_event = 1'b1;
          res.track_ended   = ended;
          nxt.vlq_acc       = '0;
          nxt.vlq_cnt       = '0;
          nxt.phase         = ended ? PH_ENDED : PH_DELTA;
        end
      end
      PH_DATA1: begin
        if (kind == KIND_PROGRAM || kind == KIND_PRESSURE) begin
          res.record_kind   = REC_CHANNEL;
          res.delta_time    = cur.delta;
          res.channel       = cur.status[3:0];
          res.event_kind    = kind;
          res.first_data    = data_byte_i;
          res.last_of_event = 1'b1;
          res_v             = 1'b1;
          nxt.vlq_acc       = '0;
          nxt.vlq_cnt       = '0;
          nxt.phase         = PH_DELTA;
        end else begin
          nxt.first_data = data_byte_i;
          nxt.phase      = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res.record_kind   = REC_CHANNEL;
        res.delta_time    = cur.delta;
        res.channel       = cur.status[3:0];
        res.event_kind    = kind;
        res.first_data    = cur.first_data;
        res.second_data   = data_byte_i;
        res.last_of_event = 1'b1;
        res_v             = 1'b1;
        nxt.vlq_acc       = '0;
        nxt.vlq_cnt       = '0;
        nxt.phase         = PH_DELTA;
      end
      default: begin
      end
    endcase

    if (err) begin
      res_v     = 1'b1;
      nxt.phase = PH_HALT;
    end

    clean = (nxt.phase == PH_DELTA && nxt.vlq_cnt == '0) ||
            nxt.phase == PH_ENDED || nxt.phase == PH_HALT;
    if (end_of_data_i && !err && !clean) begin
      res       = make_error(ERR_TRUNCATED);
      res_v     = 1'b1;
      nxt.phase = PH_HALT;
    end

    st_o        = nxt;
    res_o       = res;
    res_valid_o = res_v;
  end

endmodule

// ----- hw/rtl/mtep_checker.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser - port checker
// Watches the result channel and the input stall of the parser through its ports.
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_unit_defines.svh"

module mtep_checker import mtep_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       record_kind_o,
  input logic [VAL_W-1:0] delta_time_o,
  input logic [3:0]       channel_o,
  input logic [3:0]       event_kind_o,
  input logic [7:0]       meta_type_o,
  input logic [VAL_W-1:0] meta_length_o,
  input logic [7:0]       first_data_o,
  input logic [7:0]       second_data_o,
  input logic             last_of_event_o,
  input logic             track_ended_o,
  input logic [1:0]       error_code_o
);

  logic                 out_held;
  logic [2*VAL_W+37:0]  out_word;
  logic                 error_word;
  logic                 error_ok;
  logic                 end_word;
  logic                 end_ok;

  assign out_held   = out_valid_o && out_stall_i;
  assign out_word   = {record_kind_o, delta_time_o, channel_o, event_kind_o, meta_type_o,
                       meta_length_o, first_data_o, second_data_o, last_of_event_o,
                       track_ended_o, error_code_o};
  assign error_word = out_valid_o && record_kind_o == REC_ERROR;
  assign error_ok   = last_of_event_o && error_code_o != ERR_NONE && delta_time_o == '0;
  assign end_word   = out_valid_o && track_ended_o;
  assign end_ok     = last_of_event_o && meta_type_o == META_END_OF_TRACK &&
                      (record_kind_o == REC_META_HDR || record_kind_o == REC_META_DATA);

  `MTEP_ASSERT_NEXT(a_out_hold, out_held, out_valid_o)
  `MTEP_ASSERT_NEXT(a_out_stable, out_held, $stable(out_word))
  `MTEP_ASSERT_NOW(a_in_stall, in_stall_o, out_held)
  `MTEP_ASSERT_NOW(a_error_record, error_word, error_ok)
  `MTEP_ASSERT_NOW(a_track_end, end_word, end_ok)

endmodule

bind midi_track_event_parser_unit mtep_checker u_mtep_checker (.*);

// ----- sim/midi_track_event_parser_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser - testbench
// Feeds track chunk bytes through the input channel, predicts every record
// with a cycle-free model of the parser and compares each record taken from
// the output channel in order. Directed tracks cover the field extremes and
// the error paths. Random tracks of well-formed events with noise follow,
// under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit_tb;
  import mtep_pkg::*;

  localparam int unsigned HALF_PERIOD     = 5;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned MAX_PRINTED     = 100;
  localparam int unsigned VLQ_TOP         = (1 << VAL_W) - 1;

  typedef enum int {VLQ_MORE, VLQ_DONE, VLQ_LONG} vlq_step_e;

  class track_scoreboard;
    phase_e           phase;
    logic [VAL_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] delta;
    logic [7:0]       status;
    logic [7:0]       meta_type;
    logic [VAL_W-1:0] remaining;
    logic [7:0]       first_data;
    result_t          expected_q[$];
    int unsigned      mismatches;
    int unsigned      bytes_seen;

    function new();
      clear_state();
      mismatches = 0;
      bytes_seen = 0;
    endfunction

    function void clear_state();
      phase      = PH_DELTA;
      acc        = '0;
      cnt        = '0;
      delta      = '0;
      status     = '0;
      meta_type  = '0;
      remaining  = '0;
      first_data = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function vlq_step_e vlq_take(logic [7:0] b);
      acc = {acc[VAL_W-8:0], b[6:0]};
      if (!b[7]) begin
        cnt = '0;
        return VLQ_DONE;
      end
      if (int'(cnt) + 1 >= int'(VLQ_MAX_BYTES)) return VLQ_LONG;
      cnt = cnt + 1'b1;
      return VLQ_MORE;
    endfunction

    function void close_event(bit ended);
      acc   = '0;
      cnt   = '0;
      phase = ended ? PH_ENDED : PH_DELTA;
    endfunction

    function result_t halt_with(error_e code);
      result_t rec;
      rec               = '0;
      rec.record_kind   = REC_ERROR;
      rec.last_of_event = 1'b1;
      rec.error_code    = code;
      phase             = PH_HALT;
      return rec;
    endfunction

    function result_t channel_event(logic [7:0] d1, logic [7:0] d2);
      result_t rec;
      rec               = '0;
      rec.record_kind   = REC_CHANNEL;
      rec.delta_time    = delta;
      rec.channel       = status[3:0];
      rec.event_kind    = status[7:4];
      rec.first_data    = d1;
      rec.second_data   = d2;
      rec.last_of_event = 1'b1;
      return rec;
    endfunction

    function void note_byte(logic [7:0] b, logic sot, logic eod);
      result_t   rec;
      bit        produced;
      bit        failed;
      bit        ended;
      vlq_step_e step;
      rec      = '0;
      produced = 1'b0;
      failed   = 1'b0;
      if (sot) clear_state();
      bytes_seen++;
      case (phase)
        PH_DELTA: begin
          step = vlq_take(b);
          if (step == VLQ_LONG) begin
            rec      = halt_with(ERR_VLQ_LONG);
            produced = 1'b1;
            failed   = 1'b1;
          end else if (step == VLQ_DONE) begin
            delta = acc;
            acc   = '0;
            phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          status = b;
          if (b == STATUS_SYSEX) phase = PH_SYSEX;
          else if (b == STATUS_META) phase = PH_MTYPE;
          else if (b < STATUS_CHAN_FIRST || b > STATUS_CHAN_LAST) begin
            rec      = halt_with(ERR_STATUS);
            produced = 1'b1;
            failed   = 1'b1;
          end else phase = PH_DATA1;
        end
        PH_SYSEX: begin
          if (b == SYSEX_END) close_event(1'b0);
        end
        PH_MTYPE: begin
          meta_type = b;
          acc       = '0;
          cnt       = '0;
          phase     = PH_MLEN;
        end
        PH_MLEN: begin
          step = vlq_take(b);
          if (step == VLQ_LONG) begin
            rec      = halt_with(ERR_VLQ_LONG);
            produced = 1'b1;
            failed   = 1'b1;
          end else if (step == VLQ_DONE) begin
            ended           = (meta_type == META_END_OF_TRACK);
            remaining       = acc;
            rec.record_kind = REC_META_HDR;
            rec.delta_time  = delta;
            rec.meta_type   = meta_type;
            rec.meta_length = acc;
            produced        = 1'b1;
            if (remaining == '0) begin
              rec.last_of_event = 1'b1;
              rec.track_ended   = ended;
              close_event(ended);
            end else phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          rec.record_kind = REC_META_DATA;
          rec.delta_time  = delta;
          rec.meta_type   = meta_type;
          rec.meta_length = acc;
          rec.first_data  = b;
          produced        = 1'b1;
          remaining       = remaining - 1'b1;
          if (remaining == '0) begin
            ended             = (meta_type == META_END_OF_TRACK);
            rec.last_of_event = 1'b1;
            rec.track_ended   = ended;
            close_event(ended);
          end
        end
        PH_DATA1: begin
          if (status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE) begin
            rec      = channel_event(b, 8'h00);
            produced = 1'b1;
            close_event(1'b0);
          end else begin
            first_data = b;
            phase      = PH_DATA2;
          end
        end
        PH_DATA2: begin
          rec      = channel_event(first_data, b);
          produced = 1'b1;
          close_event(1'b0);
        end
        default: ;
      endcase
      if (eod && !failed &&
          !((phase == PH_DELTA && cnt == '0) || phase == PH_ENDED || phase == PH_HALT)) begin
        rec      = halt_with(ERR_TRUNCATED);
        produced = 1'b1;
      end
      if (produced) expected_q = {expected_q, rec};
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_record(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("record with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      check_field("record_kind", VAL_W'(got.record_kind), VAL_W'(want.record_kind));
      check_field("delta_time", got.delta_time, want.delta_time);
      check_field("channel", VAL_W'(got.channel), VAL_W'(want.channel));
      check_field("event_kind", VAL_W'(got.event_kind), VAL_W'(want.event_kind));
      check_field("meta_type", VAL_W'(got.meta_type), VAL_W'(want.meta_type));
      check_field("meta_length", got.meta_length, want.meta_length);
      check_field("first_data", VAL_W'(got.first_data), VAL_W'(want.first_data));
      check_field("second_data", VAL_W'(got.second_data), VAL_W'(want.second_data));
      check_field("last_of_event", VAL_W'(got.last_of_event), VAL_W'(want.last_of_event));
      check_field("track_ended", VAL_W'(got.track_ended), VAL_W'(want.track_ended));
      check_field("error_code", VAL_W'(got.error_code), VAL_W'(want.error_code));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [7:0]       tx_byte   = 8'h00;
  logic             tx_sot    = 1'b0;
  logic             tx_eod    = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       rx_kind;
  logic [VAL_W-1:0] rx_delta;
  logic [3:0]       rx_channel;
  logic [3:0]       rx_event_kind;
  logic [7:0]       rx_meta_type;
  logic [VAL_W-1:0] rx_meta_length;
  logic [7:0]       rx_first;
  logic [7:0]       rx_second;
  logic             rx_last;
  logic             rx_ended;
  logic [1:0]       rx_error;

  track_scoreboard  sb;
  result_t          seen_rec;
  logic [7:0]       trk[$];
  int unsigned      tx_idle_pct = 11;
  int unsigned      rx_idle_pct = 78;
  int unsigned      cycle_count = 0;

  midi_track_event_parser_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (tx_byte),
    .start_of_track_i (tx_sot),
    .end_of_data_i    (tx_eod),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .record_kind_o    (rx_kind),
    .delta_time_o     (rx_delta),
    .channel_o        (rx_channel),
    .event_kind_o     (rx_event_kind),
    .meta_type_o      (rx_meta_type),
    .meta_length_o    (rx_meta_length),
    .first_data_o     (rx_first),
    .second_data_o    (rx_second),
    .last_of_event_o  (rx_last),
    .track_ended_o    (rx_ended),
    .error_code_o     (rx_error)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_rec.record_kind   = record_kind_e'(rx_kind);
        seen_rec.delta_time    = rx_delta;
        seen_rec.channel       = rx_channel;
        seen_rec.event_kind    = rx_event_kind;
        seen_rec.meta_type     = rx_meta_type;
        seen_rec.meta_length   = rx_meta_length;
        seen_rec.first_data    = rx_first;
        seen_rec.second_data   = rx_second;
        seen_rec.last_of_event = rx_last;
        seen_rec.track_ended   = rx_ended;
        seen_rec.error_code    = error_e'(rx_error);
        sb.check_record(seen_rec);
      end
      if (in_valid && !in_stall) sb.note_byte(tx_byte, tx_sot, tx_eod);
    end
  end

  task automatic send_byte(logic [7:0] b, logic s, logic e);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    tx_byte  <= b;
    tx_sot   <= s;
    tx_eod   <= e;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic play_track(bit end_flag);
    foreach (trk[i]) send_byte(trk[i], i == 0, end_flag && (i == trk.size() - 1));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic append_byte(logic [7:0] b);
    trk = {trk, b};
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 99) < 90) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned rand_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 127);
    if (r < 80) return $urandom_range(128, 16383);
    if (r < 92) return $urandom_range(16384, (1 << 21) - 1);
    if (r < 98) return $urandom_range(1 << 21, VLQ_TOP);
    return VLQ_TOP;
  endfunction

  function automatic logic [7:0] rand_meta_type();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    if (t == META_END_OF_TRACK) t = 8'h01;
    return t;
  endfunction

  task automatic add_vlq(int unsigned v);
    int unsigned nmin;
    int unsigned n;
    nmin = 1;
    while (nmin < VLQ_MAX_BYTES && (v >> (7 * nmin)) != 0) nmin++;
    n = nmin;
    if ($urandom_range(0, 99) < 8) n = $urandom_range(nmin, VLQ_MAX_BYTES);
    for (int i = int'(n) - 1; i >= 0; i--)
      append_byte(8'(((v >> (7 * i)) & 127) | ((i > 0) ? 128 : 0)));
  endtask

  task automatic add_overlong_vlq();
    repeat (VLQ_MAX_BYTES) append_byte(8'h80 | 8'($urandom_range(0, 127)));
  endtask

  task automatic add_event();
    int unsigned r;
    int unsigned len;
    logic [7:0]  st;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_overlong_vlq();
      return;
    end
    add_vlq(rand_ticks());
    if (r < 52) begin
      st = 8'($urandom_range(STATUS_CHAN_FIRST, STATUS_CHAN_LAST));
      append_byte(st);
      append_byte(rand_data());
      if (st[7:4] != KIND_PROGRAM && st[7:4] != KIND_PRESSURE) append_byte(rand_data());
    end else if (r < 74) begin
      append_byte(STATUS_META);
      append_byte(rand_meta_type());
      len = $urandom_range(0, 99);
      len = (len < 15) ? 0 : (len < 95) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      add_vlq(len);
      repeat (len) append_byte(8'($urandom_range(0, 255)));
    end else if (r < 88) begin
      append_byte(STATUS_SYSEX);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        append_byte((b == SYSEX_END) ? 8'h77 : b);
      end
      append_byte(SYSEX_END);
    end else if (r < 95) begin
      if ($urandom_range(0, 1)) append_byte(8'($urandom_range(0, 127)));
      else append_byte(8'($urandom_range(8'hF1, 8'hFE)));
    end else begin
      append_byte(STATUS_META);
      append_byte(rand_meta_type());
      add_overlong_vlq();
    end
  endtask

  task automatic add_end_of_track();
    int unsigned len;
    add_vlq(rand_ticks());
    append_byte(STATUS_META);
    append_byte(META_END_OF_TRACK);
    len = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 2);
    add_vlq(len);
    repeat (len) append_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_track();
    int unsigned r;
    int unsigned cut;
    bit          end_flag;
    trk.delete();
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(4, 16)) append_byte(8'($urandom_range(0, 255)));
      play_track(1'($urandom_range(0, 1)));
      return;
    end
    repeat ($urandom_range(1, 10)) add_event();
    end_flag = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      add_end_of_track();
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
      end_flag = 1'($urandom_range(0, 1));
    end else if (r < 65) begin
      end_flag = 1'b1;
    end else if (r < 82) begin
      cut = $urandom_range(1, (trk.size() > 3) ? 3 : trk.size() - 1);
      repeat (cut) void'(trk.pop_back());
      end_flag = ($urandom_range(0, 99) < 80);
    end else if (r < 88) begin
      add_vlq(rand_ticks());
      append_byte(STATUS_META);
      append_byte(rand_meta_type());
      add_vlq($urandom_range(1 << 21, VLQ_TOP));
      repeat ($urandom_range(0, 3)) append_byte(rand_data());
      end_flag = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) < 10)
      trk[$urandom_range(1, trk.size() - 1)] = 8'($urandom_range(0, 255));
    play_track(end_flag);
  endtask

  task automatic run_directed();
    trk = '{8'h00, 8'h90, 8'h3C, 8'h7F,
            8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hCF, 8'hFF,
            8'h00, 8'hF0, 8'hF7,
            8'h81, 8'h00, 8'hFF, 8'h2F, 8'h01, 8'hAA,
            8'h55};
    play_track(1'b1);
    trk = '{8'h80, 8'h80, 8'h80, 8'h80};
    play_track(1'b0);
    trk = '{8'h00, 8'h40};
    play_track(1'b0);
    trk = '{8'h00, 8'hF5};
    play_track(1'b0);
    trk = '{8'h00, 8'h90};
    play_track(1'b1);
  endtask

  initial begin
    int unsigned target;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      target = sb.bytes_seen + ITEMS_PER_PHASE;
      while (sb.bytes_seen < target) random_track();
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
